### rtl/svc_pkg.sv
// types and constants shared by the signed varint codec
package svc_pkg;

    localparam logic       OP_ENCODE = 1'b0;
    localparam logic       OP_DECODE = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_ROOM   = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;
    localparam logic [1:0] ST_TOO_LONG  = 2'd3;

    localparam logic [7:0] CONT_BIT  = 8'h80;
    localparam logic [7:0] SIGN_BIT  = 8'h40;
    localparam logic [7:0] HEAD_MASK = 8'h3f;
    localparam logic [7:0] TAIL_MASK = 8'h7f;

    localparam logic [14:0] ONE_BYTE_MAX = 15'd63;
    localparam logic [14:0] TWO_BYTE_MAX = 15'd8191;

    typedef struct packed {
        logic        operation;
        logic [15:0] value_in;
        logic [7:0]  in_byte0;
        logic [7:0]  in_byte1;
        logic [7:0]  in_byte2;
        logic [1:0]  avail_count;
    } item_t;

    typedef struct packed {
        logic [13:0] value_out;
        logic [7:0]  out_byte0;
        logic [7:0]  out_byte1;
        logic [7:0]  out_byte2;
        logic [1:0]  byte_length;
        logic [1:0]  status;
    } result_t;

endpackage

### rtl/signed_varint_codec_core.sv
// signed varint codec core: encodes a value into one to three bytes or decodes bytes
//
// input channel (s_*): one beat carries an operation, the value to encode, up to three
// encoded bytes and a byte count (room for encode, bytes available for decode).
// result channel (m_*): one beat per input beat, in order, carrying the decoded value,
// the encoded bytes, the byte length and a status code.
// pipeline: a beat accepted on the input channel is held in the input register, then moves
// into the result register, which drives m_valid and the result fields.
// throughput: one beat per cycle while m_ready is high, set by the single pass of
// packing logic between the two registers.
// stall: while m_ready is low the result register holds; the input register still takes
// one more beat, after which s_ready follows m_ready. nothing is dropped or repeated.
// reset: aresetn low at a rising edge empties both registers; m_valid goes low and
// s_ready is high once reset is released. the block holds no other state.
module signed_varint_codec_core
    import svc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_operation,
    input  logic signed [15:0] s_value_in,
    input  logic [7:0]        s_in_byte0,
    input  logic [7:0]        s_in_byte1,
    input  logic [7:0]        s_in_byte2,
    input  logic [1:0]        s_avail_count,
    output logic              m_valid,
    input  logic              m_ready,
    output logic signed [13:0] m_value_out,
    output logic [7:0]        m_out_byte0,
    output logic [7:0]        m_out_byte1,
    output logic [7:0]        m_out_byte2,
    output logic [1:0]        m_byte_length,
    output logic [1:0]        m_status
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_result_reg;
    logic    out_load;
    logic    in_load;
    result_t result_next;

    logic        neg;
    logic [14:0] mag;
    logic [7:0]  head;
    logic [12:0] dec_mag;
    logic [13:0] dec_value;

    assign out_load = !out_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || out_load;
    assign in_load  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_item_reg.operation   <= s_operation;
            in_item_reg.value_in    <= s_value_in;
            in_item_reg.in_byte0    <= s_in_byte0;
            in_item_reg.in_byte1    <= s_in_byte1;
            in_item_reg.in_byte2    <= s_in_byte2;
            in_item_reg.avail_count <= s_avail_count;
        end
    end

    // encode side
    assign neg  = in_item_reg.value_in[15];
    assign mag  = neg ? ~in_item_reg.value_in[14:0] : in_item_reg.value_in[14:0];
    assign head = neg ? SIGN_BIT : 8'h00;

    // decode side
    assign dec_mag   = {in_item_reg.in_byte0[5:0], in_item_reg.in_byte1[6:0]};
    assign dec_value = (in_item_reg.in_byte0 & SIGN_BIT) != 8'h00
                       ? ~{1'b0, (in_item_reg.in_byte0[7] ? dec_mag
                                                          : {7'd0, in_item_reg.in_byte0[5:0]})}
                       :  {1'b0, (in_item_reg.in_byte0[7] ? dec_mag
                                                          : {7'd0, in_item_reg.in_byte0[5:0]})};

    always_comb begin
        result_next = '0;
        if (in_item_reg.operation == OP_ENCODE) begin
            if (in_item_reg.avail_count == 2'd0) begin
                result_next.status = ST_NO_ROOM;
            end else if (mag <= ONE_BYTE_MAX) begin
                result_next.out_byte0   = head | (mag[7:0] & HEAD_MASK);
                result_next.byte_length = 2'd1;
                result_next.status      = ST_OK;
            end else if (mag <= TWO_BYTE_MAX) begin
                result_next.out_byte0   = head | CONT_BIT | ({1'b0, mag[13:7]} & HEAD_MASK);
                result_next.out_byte1   = mag[7:0] & TAIL_MASK;
                result_next.byte_length = 2'd2;
                result_next.status      = ST_OK;
            end else begin
                result_next.out_byte0   = head | CONT_BIT | {7'd0, mag[14]};
                result_next.out_byte1   = mag[14:7] | CONT_BIT;
                result_next.out_byte2   = mag[7:0] & TAIL_MASK;
                result_next.byte_length = 2'd3;
                result_next.status      = ST_OK;
            end
        end else begin
            if (in_item_reg.avail_count == 2'd0) begin
                result_next.status = ST_TRUNCATED;
            end else if (!in_item_reg.in_byte0[7]) begin
                result_next.value_out   = dec_value;
                result_next.byte_length = 2'd1;
                result_next.status      = ST_OK;
            end else if (in_item_reg.avail_count == 2'd1) begin
                result_next.status = ST_TRUNCATED;
            end else if (in_item_reg.in_byte1[7]) begin
                result_next.status = (in_item_reg.avail_count == 2'd2) ? ST_TRUNCATED
                                                                       : ST_TOO_LONG;
            end else begin
                result_next.value_out   = dec_value;
                result_next.byte_length = 2'd2;
                result_next.status      = ST_OK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && in_valid_reg) begin
            out_result_reg <= result_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_value_out   = out_result_reg.value_out;
    assign m_out_byte0   = out_result_reg.out_byte0;
    assign m_out_byte1   = out_result_reg.out_byte1;
    assign m_out_byte2   = out_result_reg.out_byte2;
    assign m_byte_length = out_result_reg.byte_length;
    assign m_status      = out_result_reg.status;

endmodule

### dv/tb_signed_varint_codec_core.sv
// testbench for the signed varint codec core: directed, round-trip and random beats
`timescale 1ns / 1ps

module tb_signed_varint_codec_core;
    import svc_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_MAX   = 10;

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              s_valid       = 1'b0;
    logic              s_ready;
    logic              s_operation   = OP_ENCODE;
    logic signed [15:0] s_value_in   = '0;
    logic [7:0]        s_in_byte0    = '0;
    logic [7:0]        s_in_byte1    = '0;
    logic [7:0]        s_in_byte2    = '0;
    logic [1:0]        s_avail_count = '0;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    logic signed [13:0] m_value_out;
    logic [7:0]        m_out_byte0;
    logic [7:0]        m_out_byte1;
    logic [7:0]        m_out_byte2;
    logic [1:0]        m_byte_length;
    logic [1:0]        m_status;

    result_t expected_results[$];
    int      mismatch_count     = 0;
    int      idle_cycles        = 0;
    int      feed_burst         = 0;
    int      drain_burst        = 0;
    int      result_hold_cycles = 0;

    signed_varint_codec_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_value_in    (s_value_in),
        .s_in_byte0    (s_in_byte0),
        .s_in_byte1    (s_in_byte1),
        .s_in_byte2    (s_in_byte2),
        .s_avail_count (s_avail_count),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_value_out   (m_value_out),
        .m_out_byte0   (m_out_byte0),
        .m_out_byte1   (m_out_byte1),
        .m_out_byte2   (m_out_byte2),
        .m_byte_length (m_byte_length),
        .m_status      (m_status)
    );

    always #2 aclk = ~aclk;

    function automatic result_t codec_result(item_t it);
        result_t     r;
        logic        neg;
        logic [14:0] enc_mag;
        logic [12:0] dec_mag;
        r = '0;
        dec_mag = '0;
        if (it.operation == OP_ENCODE) begin
            neg = it.value_in[15];
            enc_mag = neg ? ~it.value_in[14:0] : it.value_in[14:0];
            if (it.avail_count == 2'd0) begin
                r.status = ST_NO_ROOM;
            end else if (enc_mag <= ONE_BYTE_MAX) begin
                r.out_byte0   = {1'b0, neg, enc_mag[5:0]};
                r.byte_length = 2'd1;
                r.status      = ST_OK;
            end else if (enc_mag <= TWO_BYTE_MAX) begin
                r.out_byte0   = {1'b1, neg, enc_mag[12:7]};
                r.out_byte1   = {1'b0, enc_mag[6:0]};
                r.byte_length = 2'd2;
                r.status      = ST_OK;
            end else begin
                r.out_byte0   = {1'b1, neg, 5'd0, enc_mag[14]};
                r.out_byte1   = {1'b1, enc_mag[13:7]};
                r.out_byte2   = {1'b0, enc_mag[6:0]};
                r.byte_length = 2'd3;
                r.status      = ST_OK;
            end
        end else begin
            if (it.avail_count == 2'd0) begin
                r.status = ST_TRUNCATED;
            end else if (!it.in_byte0[7]) begin
                dec_mag       = {7'd0, it.in_byte0[5:0]};
                r.byte_length = 2'd1;
                r.status      = ST_OK;
            end else if (it.avail_count == 2'd1) begin
                r.status = ST_TRUNCATED;
            end else if (it.in_byte1[7]) begin
                r.status = (it.avail_count == 2'd2) ? ST_TRUNCATED : ST_TOO_LONG;
            end else begin
                dec_mag       = {it.in_byte0[5:0], it.in_byte1[6:0]};
                r.byte_length = 2'd2;
                r.status      = ST_OK;
            end
            if (r.status == ST_OK) begin
                r.value_out = it.in_byte0[6] ? ~{1'b0, dec_mag} : {1'b0, dec_mag};
            end
        end
        return r;
    endfunction

    function automatic item_t make_item(logic op, logic [15:0] value, logic [7:0] b0,
                                        logic [7:0] b1, logic [7:0] b2, logic [1:0] avail);
        item_t it;
        it.operation   = op;
        it.value_in    = value;
        it.in_byte0    = b0;
        it.in_byte1    = b1;
        it.in_byte2    = b2;
        it.avail_count = avail;
        return it;
    endfunction

    // a quarter of the values span the one byte range, a quarter just past the two byte range, the rest the full range
    function automatic logic [15:0] random_value();
        int v;
        case ($urandom_range(0, 3))
            0: begin
                v = $urandom_range(0, 127) - 64;
            end
            1: begin
                v = $urandom_range(0, 16399) - 8200;
            end
            default: begin
                v = $urandom;
            end
        endcase
        return v[15:0];
    endfunction

    // decodes are mostly real encodings with a fitting byte count, the rest noise
    function automatic item_t random_item();
        item_t   it;
        result_t enc;
        it = make_item(1'($urandom_range(0, 1)), random_value(), 8'($urandom), 8'($urandom),
                       8'($urandom), 2'($urandom_range(0, 3)));
        if (it.operation == OP_DECODE && $urandom_range(0, 9) < 7) begin
            enc = codec_result(make_item(OP_ENCODE, random_value(), 8'd0, 8'd0, 8'd0, 2'd3));
            it.in_byte0 = enc.out_byte0;
            if (enc.byte_length >= 2'd2) begin
                it.in_byte1 = enc.out_byte1;
            end
            if ($urandom_range(0, 7) != 0) begin
                it.avail_count = 2'($urandom_range(enc.byte_length, 3));
            end
        end
        return it;
    endfunction

    task automatic send_item(item_t it);
        int gap;
        if (feed_burst > 0) begin
            gap = 0;
            feed_burst--;
        end else begin
            gap = $urandom_range(0, 16);
            if ($urandom_range(0, 19) == 0) begin
                feed_burst = $urandom_range(8, 40);
            end
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= it.operation;
        s_value_in    <= it.value_in;
        s_in_byte0    <= it.in_byte0;
        s_in_byte1    <= it.in_byte1;
        s_in_byte2    <= it.in_byte2;
        s_avail_count <= it.avail_count;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic test_encode_limits();
        int vals[12] = '{0, 63, 64, -1, -64, -65, 8191, 8192, -8192, -8193, 32767, -32768};
        foreach (vals[i]) begin
            send_item(make_item(OP_ENCODE, 16'(vals[i]), 8'($urandom), 8'($urandom),
                                8'($urandom), 2'(1 + i % 3)));
        end
        // too little room still gives the full encoding, zero room gives none
        send_item(make_item(OP_ENCODE, 16'h8000, 8'hff, 8'hff, 8'hff, 2'd1));
        send_item(make_item(OP_ENCODE, 16'd100, 8'h00, 8'h00, 8'h00, 2'd0));
        send_item(make_item(OP_ENCODE, 16'h7fff, 8'hff, 8'hff, 8'hff, 2'd0));
    endtask

    task automatic test_decode_cases();
        send_item(make_item(OP_DECODE, 16'($urandom), 8'h05, 8'h00, 8'h00, 2'd0));
        send_item(make_item(OP_DECODE, 16'($urandom), 8'h3f, 8'hff, 8'hff, 2'd1));
        send_item(make_item(OP_DECODE, 16'($urandom), 8'h7f, 8'h00, 8'hff, 2'd2));
        send_item(make_item(OP_DECODE, 16'($urandom), 8'h00, 8'hff, 8'h00, 2'd3));
        send_item(make_item(OP_DECODE, 16'($urandom), 8'h80, 8'h00, 8'h00, 2'd1));
        send_item(make_item(OP_DECODE, 16'($urandom), 8'h80, 8'h80, 8'h00, 2'd2));
        send_item(make_item(OP_DECODE, 16'($urandom), 8'hff, 8'hff, 8'hff, 2'd3));
        send_item(make_item(OP_DECODE, 16'($urandom), 8'h80, 8'h00, 8'hff, 2'd2));
        send_item(make_item(OP_DECODE, 16'($urandom), 8'hbf, 8'h7f, 8'h00, 2'd2));
        send_item(make_item(OP_DECODE, 16'($urandom), 8'hff, 8'h7f, 8'hff, 2'd3));
        send_item(make_item(OP_DECODE, 16'($urandom), 8'hc0, 8'h00, 8'h00, 2'd2));
    endtask

    task automatic test_round_trip();
        item_t   enc_item;
        result_t enc;
        repeat (300) begin
            enc_item = make_item(OP_ENCODE, random_value(), 8'($urandom), 8'($urandom),
                                 8'($urandom), 2'($urandom_range(1, 3)));
            send_item(enc_item);
            enc = codec_result(enc_item);
            send_item(make_item(OP_DECODE, 16'($urandom), enc.out_byte0, enc.out_byte1,
                                enc.out_byte2, 2'($urandom_range(enc.byte_length, 3))));
        end
    endtask

    task automatic test_backpressure();
        feed_burst         = 48;
        result_hold_cycles = 64;
        repeat (40) send_item(random_item());
    endtask

    task automatic test_random_mix();
        repeat (1190) send_item(random_item());
    endtask

    initial begin : result_sink
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (result_hold_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (result_hold_cycles) @(posedge aclk);
                result_hold_cycles = 0;
            end
            if (drain_burst > 0) begin
                stall = 0;
                drain_burst--;
            end else begin
                stall = $urandom_range(0, 16);
                if ($urandom_range(0, 19) == 0) begin
                    drain_burst = $urandom_range(8, 40);
                end
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin : beat_monitor
        item_t   seen;
        result_t got;
        result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                seen = make_item(s_operation, s_value_in, s_in_byte0, s_in_byte1, s_in_byte2,
                                 s_avail_count);
                expected_results.push_back(codec_result(seen));
            end
            if (m_valid && m_ready) begin
                got.value_out   = m_value_out;
                got.out_byte0   = m_out_byte0;
                got.out_byte1   = m_out_byte1;
                got.out_byte2   = m_out_byte2;
                got.byte_length = m_byte_length;
                got.status      = m_status;
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX) begin
                        $display("result beat with nothing expected: value %0d bytes %h %h %h",
                                 $signed(got.value_out), got.out_byte0, got.out_byte1,
                                 got.out_byte2);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX) begin
                            $display("mismatch exp: value %0d bytes %h %h %h len %0d status %0d",
                                     $signed(want.value_out), want.out_byte0, want.out_byte1,
                                     want.out_byte2, want.byte_length, want.status);
                            $display("         got: value %0d bytes %h %h %h len %0d status %0d",
                                     $signed(got.value_out), got.out_byte0, got.out_byte1,
                                     got.out_byte2, got.byte_length, got.status);
                        end
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_encode_limits();
        test_decode_cases();
        test_round_trip();
        test_backpressure();
        test_random_mix();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
